@@ sv/imuq_pkg.sv @@
// ----------------------------------------------------------------------------
// imuq_pkg
// Types, constants and the micro-program of the attitude filter core.
// ----------------------------------------------------------------------------
`default_nettype none

package imuq_pkg;

    // Datapath types
    typedef logic signed [32:0] t_opnd;
    typedef logic signed [65:0] t_prod;
    typedef logic signed [47:0] t_acc;
    typedef logic signed [35:0] t_nin;
    typedef logic signed [31:0] t_q;

    localparam int STEP_W = 6;
    localparam logic [STEP_W-1:0] STEP_RATE = 6'd27;
    localparam logic [STEP_W-1:0] STEP_LAST = 6'd41;
    localparam t_q QONE = 32'sh4000_0000;
    localparam logic [31:0] PROP_GAIN_RST = 32'h0100_0000;

    // Configuration register indexes
    localparam logic CFG_PROP_GAIN  = 1'b0;
    localparam logic CFG_INTEG_GAIN = 1'b1;

    // Operand sources
    typedef enum logic [4:0] {
        SRC_ZERO, SRC_ONE, SRC_NHALF,
        SRC_QW, SRC_QX, SRC_QY, SRC_QZ,
        SRC_AH0, SRC_AH1, SRC_AH2,
        SRC_HV0, SRC_HV1, SRC_HV2,
        SRC_E0, SRC_E1, SRC_E2,
        SRC_G0, SRC_G1, SRC_G2,
        SRC_FB0, SRC_FB1, SRC_FB2,
        SRC_H0, SRC_H1, SRC_H2,
        SRC_DT, SRC_T, SRC_PG, SRC_IG
    } t_src;

    // Write-back destinations
    typedef enum logic [4:0] {
        DST_NONE,
        DST_HV0, DST_HV1, DST_HV2,
        DST_E0, DST_E1, DST_E2,
        DST_T,
        DST_FB0, DST_FB1, DST_FB2,
        DST_G0, DST_G1, DST_G2,
        DST_H0, DST_H1, DST_H2,
        DST_QN0, DST_QN1, DST_QN2, DST_QN3
    } t_dst;

    // Product scaling
    typedef enum logic [2:0] {SH_0, SH_19, SH_30, SH_32, SH_38} t_sh;

    // Execution condition on the integral gain
    typedef enum logic [1:0] {IGC_ANY, IGC_ON, IGC_OFF} t_igc;

    typedef struct packed {
        t_src a;
        t_src b;
        t_sh  sh;
        logic neg;
        logic first;
        t_src init;
        t_dst dst;
        logic sat;
        t_igc igc;
    } t_uop;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ANORM, ST_EXEC, ST_QSTART, ST_QNORM, ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        NS_IDLE, NS_SQR, NS_SCALE, NS_SQRT, NS_DLOAD, NS_DIV
    } t_nstate;

    typedef struct packed {
        logic done;
        logic nonzero;
    } t_norm_rsp;

    function automatic t_q sat32(input t_acc v);
        t_q r;
        if (v > 48'sd2147483647) begin
            r = 32'sh7fff_ffff;
        end else if (v < -48'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic t_uop mk(input t_src a, input t_src b, input t_sh sh,
                                input logic neg, input logic first, input t_src init,
                                input t_dst dst, input logic sat, input t_igc igc);
        t_uop u;
        u.a = a; u.b = b; u.sh = sh; u.neg = neg; u.first = first;
        u.init = init; u.dst = dst; u.sat = sat; u.igc = igc;
        return u;
    endfunction

    // Micro-program: each step is one multiply, scaled and added to the accumulator
    function automatic t_uop uop_rom(input logic [STEP_W-1:0] step);
        t_uop u;
        case (step)
            // estimated gravity
            6'd0:  u = mk(SRC_QX, SRC_QZ, SH_30, 1'b0, 1'b1, SRC_ZERO, DST_NONE, 1'b0, IGC_ANY);
            6'd1:  u = mk(SRC_QW, SRC_QY, SH_30, 1'b1, 1'b0, SRC_ZERO, DST_HV0, 1'b0, IGC_ANY);
            6'd2:  u = mk(SRC_QW, SRC_QX, SH_30, 1'b0, 1'b1, SRC_ZERO, DST_NONE, 1'b0, IGC_ANY);
            6'd3:  u = mk(SRC_QY, SRC_QZ, SH_30, 1'b0, 1'b0, SRC_ZERO, DST_HV1, 1'b0, IGC_ANY);
            6'd4:  u = mk(SRC_QW, SRC_QW, SH_30, 1'b0, 1'b1, SRC_NHALF, DST_NONE, 1'b0, IGC_ANY);
            6'd5:  u = mk(SRC_QZ, SRC_QZ, SH_30, 1'b0, 1'b0, SRC_ZERO, DST_HV2, 1'b0, IGC_ANY);
            // error: measured x estimated
            6'd6:  u = mk(SRC_AH1, SRC_HV2, SH_30, 1'b0, 1'b1, SRC_ZERO, DST_NONE, 1'b0, IGC_ANY);
            6'd7:  u = mk(SRC_AH2, SRC_HV1, SH_30, 1'b1, 1'b0, SRC_ZERO, DST_E0, 1'b1, IGC_ANY);
            6'd8:  u = mk(SRC_AH2, SRC_HV0, SH_30, 1'b0, 1'b1, SRC_ZERO, DST_NONE, 1'b0, IGC_ANY);
            6'd9:  u = mk(SRC_AH0, SRC_HV2, SH_30, 1'b1, 1'b0, SRC_ZERO, DST_E1, 1'b1, IGC_ANY);
            6'd10: u = mk(SRC_AH0, SRC_HV1, SH_30, 1'b0, 1'b1, SRC_ZERO, DST_NONE, 1'b0, IGC_ANY);
            6'd11: u = mk(SRC_AH1, SRC_HV0, SH_30, 1'b1, 1'b0, SRC_ZERO, DST_E2, 1'b1, IGC_ANY);
            // feedback, x axis
            6'd12: u = mk(SRC_E0, SRC_DT, SH_32, 1'b0, 1'b1, SRC_ZERO, DST_T, 1'b0, IGC_ON);
            6'd13: u = mk(SRC_IG, SRC_T, SH_38, 1'b0, 1'b1, SRC_FB0, DST_FB0, 1'b1, IGC_ON);
            6'd14: u = mk(SRC_ZERO, SRC_ONE, SH_0, 1'b0, 1'b1, SRC_ZERO, DST_FB0, 1'b0, IGC_OFF);
            6'd15: u = mk(SRC_FB0, SRC_ONE, SH_0, 1'b0, 1'b1, SRC_G0, DST_NONE, 1'b0, IGC_ANY);
            6'd16: u = mk(SRC_PG, SRC_E0, SH_38, 1'b0, 1'b0, SRC_ZERO, DST_G0, 1'b1, IGC_ANY);
            // feedback, y axis
            6'd17: u = mk(SRC_E1, SRC_DT, SH_32, 1'b0, 1'b1, SRC_ZERO, DST_T, 1'b0, IGC_ON);
            6'd18: u = mk(SRC_IG, SRC_T, SH_38, 1'b0, 1'b1, SRC_FB1, DST_FB1, 1'b1, IGC_ON);
            6'd19: u = mk(SRC_ZERO, SRC_ONE, SH_0, 1'b0, 1'b1, SRC_ZERO, DST_FB1, 1'b0, IGC_OFF);
            6'd20: u = mk(SRC_FB1, SRC_ONE, SH_0, 1'b0, 1'b1, SRC_G1, DST_NONE, 1'b0, IGC_ANY);
            6'd21: u = mk(SRC_PG, SRC_E1, SH_38, 1'b0, 1'b0, SRC_ZERO, DST_G1, 1'b1, IGC_ANY);
            // feedback, z axis
            6'd22: u = mk(SRC_E2, SRC_DT, SH_32, 1'b0, 1'b1, SRC_ZERO, DST_T, 1'b0, IGC_ON);
            6'd23: u = mk(SRC_IG, SRC_T, SH_38, 1'b0, 1'b1, SRC_FB2, DST_FB2, 1'b1, IGC_ON);
            6'd24: u = mk(SRC_ZERO, SRC_ONE, SH_0, 1'b0, 1'b1, SRC_ZERO, DST_FB2, 1'b0, IGC_OFF);
            6'd25: u = mk(SRC_FB2, SRC_ONE, SH_0, 1'b0, 1'b1, SRC_G2, DST_NONE, 1'b0, IGC_ANY);
            6'd26: u = mk(SRC_PG, SRC_E2, SH_38, 1'b0, 1'b0, SRC_ZERO, DST_G2, 1'b1, IGC_ANY);
            // half angles
            6'd27: u = mk(SRC_G0, SRC_DT, SH_19, 1'b0, 1'b1, SRC_ZERO, DST_H0, 1'b1, IGC_ANY);
            6'd28: u = mk(SRC_G1, SRC_DT, SH_19, 1'b0, 1'b1, SRC_ZERO, DST_H1, 1'b1, IGC_ANY);
            6'd29: u = mk(SRC_G2, SRC_DT, SH_19, 1'b0, 1'b1, SRC_ZERO, DST_H2, 1'b1, IGC_ANY);
            // quaternion integration
            6'd30: u = mk(SRC_QX, SRC_H0, SH_30, 1'b1, 1'b1, SRC_QW, DST_NONE, 1'b0, IGC_ANY);
            6'd31: u = mk(SRC_QY, SRC_H1, SH_30, 1'b1, 1'b0, SRC_ZERO, DST_NONE, 1'b0, IGC_ANY);
            6'd32: u = mk(SRC_QZ, SRC_H2, SH_30, 1'b1, 1'b0, SRC_ZERO, DST_QN0, 1'b0, IGC_ANY);
            6'd33: u = mk(SRC_QW, SRC_H0, SH_30, 1'b0, 1'b1, SRC_QX, DST_NONE, 1'b0, IGC_ANY);
            6'd34: u = mk(SRC_QY, SRC_H2, SH_30, 1'b0, 1'b0, SRC_ZERO, DST_NONE, 1'b0, IGC_ANY);
            6'd35: u = mk(SRC_QZ, SRC_H1, SH_30, 1'b1, 1'b0, SRC_ZERO, DST_QN1, 1'b0, IGC_ANY);
            6'd36: u = mk(SRC_QW, SRC_H1, SH_30, 1'b0, 1'b1, SRC_QY, DST_NONE, 1'b0, IGC_ANY);
            6'd37: u = mk(SRC_QX, SRC_H2, SH_30, 1'b1, 1'b0, SRC_ZERO, DST_NONE, 1'b0, IGC_ANY);
            6'd38: u = mk(SRC_QZ, SRC_H0, SH_30, 1'b0, 1'b0, SRC_ZERO, DST_QN2, 1'b0, IGC_ANY);
            6'd39: u = mk(SRC_QW, SRC_H2, SH_30, 1'b0, 1'b1, SRC_QZ, DST_NONE, 1'b0, IGC_ANY);
            6'd40: u = mk(SRC_QX, SRC_H1, SH_30, 1'b0, 1'b0, SRC_ZERO, DST_NONE, 1'b0, IGC_ANY);
            6'd41: u = mk(SRC_QY, SRC_H0, SH_30, 1'b1, 1'b0, SRC_ZERO, DST_QN3, 1'b0, IGC_ANY);
            default: u = mk(SRC_ZERO, SRC_ZERO, SH_0, 1'b0, 1'b0, SRC_ZERO, DST_NONE, 1'b0,
                            IGC_ANY);
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

@@ sv/imuq_if.sv @@
// ----------------------------------------------------------------------------
// imuq_if
// Channel interfaces of the attitude filter: sample in, attitude out, config.
// ----------------------------------------------------------------------------
`default_nettype none

interface imuq_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] rate_x;
    logic signed [31:0] rate_y;
    logic signed [31:0] rate_z;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
    logic        [31:0] step_time;
    modport source(output valid, rate_x, rate_y, rate_z, accel_x, accel_y, accel_z,
                   step_time, input ready);
    modport sink(input valid, rate_x, rate_y, rate_z, accel_x, accel_y, accel_z,
                 step_time, output ready);
endinterface

interface imuq_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] att_w;
    logic signed [31:0] att_x;
    logic signed [31:0] att_y;
    logic signed [31:0] att_z;
    logic               corrected;
    modport source(output valid, att_w, att_x, att_y, att_z, corrected, input ready);
    modport sink(input valid, att_w, att_x, att_y, att_z, corrected, output ready);
endinterface

interface imuq_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [31:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ sv/imu_attitude_quaternion_filter_core.sv @@
// ----------------------------------------------------------------------------
// imu_attitude_quaternion_filter_core
// Mahony attitude filter: one IMU sample in, one attitude quaternion out.
// ----------------------------------------------------------------------------
// Channels: i_in takes one sample (rates, accelerations, step time) per item;
// o_out gives the renormalised quaternion in Q2.30 and the corrected flag;
// i_cfg writes the proportional (index 0) and integral (index 1) gains and
// is always ready.
// Flow: a sample is taken only while the core is idle. It runs through the
// accelerometer normaliser (an all-zero vector skips its root and division),
// a micro-program of up to 42 multiply steps on the one shared multiplier
// (some steps are skipped, depending on whether the integral gain is zero; an
// all-zero vector starts at the half-angle steps), then the quaternion
// normaliser. The normaliser's bit-serial root and division take most of the
// time from accept to result valid.
// Output: the result sits in an output register; the core is ready for the
// next sample while it waits. If the receiver still holds the previous
// result when a new one is finished, the core waits until it is taken.
// Reset: quaternion returns to (1, 0, 0, 0), integral terms to zero,
// proportional gain to 1.0 and integral gain to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_attitude_quaternion_filter_core
    import imuq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    imuq_in_if.sink     i_in,
    imuq_out_if.source  o_out,
    imuq_cfg_if.sink    i_cfg
);

    t_state             r_state, n_state;
    logic [STEP_W-1:0]  r_step;
    logic               r_phase;
    logic               r_corr;
    logic [31:0]        r_pg;
    logic [31:0]        r_ig;
    t_q                 r_q [4];
    t_q                 r_fb [3];
    t_q                 r_g [3];
    t_q                 r_ah [3];
    logic signed [32:0] r_hv [3];
    t_q                 r_e [3];
    t_q                 r_h [3];
    t_q                 r_t;
    logic [31:0]        r_dt;
    t_nin               r_qn [4];
    t_acc               r_acc;
    logic               r_out_valid;
    t_q                 r_res [4];
    logic               r_res_corr;

    t_uop               uop;
    logic               skip;
    logic               step_end;
    logic signed [35:0] a_val, b_val, init_val;
    t_prod              prod;
    t_prod              term_w;
    t_acc               term, base, acc_new;
    t_acc               wr_val;
    logic               mul_en;
    logic               norm_start;
    t_nin               norm_in [4];
    t_norm_rsp          norm_rsp;
    t_q                 norm_out [4];
    logic               accept;
    logic               out_free;

    // Operand select over the working registers
    function automatic logic signed [35:0] pick(input t_src s);
        logic signed [35:0] v;
        case (s)
            SRC_ZERO:  v = '0;
            SRC_ONE:   v = 36'sd1;
            SRC_NHALF: v = -36'sd536870912;
            SRC_QW:    v = 36'(r_q[0]);
            SRC_QX:    v = 36'(r_q[1]);
            SRC_QY:    v = 36'(r_q[2]);
            SRC_QZ:    v = 36'(r_q[3]);
            SRC_AH0:   v = 36'(r_ah[0]);
            SRC_AH1:   v = 36'(r_ah[1]);
            SRC_AH2:   v = 36'(r_ah[2]);
            SRC_HV0:   v = 36'(r_hv[0]);
            SRC_HV1:   v = 36'(r_hv[1]);
            SRC_HV2:   v = 36'(r_hv[2]);
            SRC_E0:    v = 36'(r_e[0]);
            SRC_E1:    v = 36'(r_e[1]);
            SRC_E2:    v = 36'(r_e[2]);
            SRC_G0:    v = 36'(r_g[0]);
            SRC_G1:    v = 36'(r_g[1]);
            SRC_G2:    v = 36'(r_g[2]);
            SRC_FB0:   v = 36'(r_fb[0]);
            SRC_FB1:   v = 36'(r_fb[1]);
            SRC_FB2:   v = 36'(r_fb[2]);
            SRC_H0:    v = 36'(r_h[0]);
            SRC_H1:    v = 36'(r_h[1]);
            SRC_H2:    v = 36'(r_h[2]);
            SRC_DT:    v = $signed({4'b0, r_dt});
            SRC_T:     v = 36'(r_t);
            SRC_PG:    v = $signed({4'b0, r_pg});
            SRC_IG:    v = $signed({4'b0, r_ig});
            default:   v = '0;
        endcase
        return v;
    endfunction

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    // Decode the current step
    always_comb begin
        uop      = uop_rom(r_step);
        skip     = ((uop.igc == IGC_ON) && (r_ig == '0)) ||
                   ((uop.igc == IGC_OFF) && (r_ig != '0));
        step_end = (r_state == ST_EXEC) && (r_phase || skip);
        a_val    = pick(uop.a);
        b_val    = pick(uop.b);
        init_val = pick(uop.init);
        mul_en   = (r_state == ST_EXEC) && !r_phase && !skip;
    end

    imuq_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (a_val[32:0]),
        .i_b    (b_val[32:0]),
        .o_prod (prod)
    );

    // Scale the product and accumulate
    always_comb begin
        case (uop.sh)
            SH_0:    term_w = prod;
            SH_19:   term_w = prod >>> 19;
            SH_30:   term_w = prod >>> 30;
            SH_32:   term_w = prod >>> 32;
            SH_38:   term_w = prod >>> 38;
            default: term_w = prod;
        endcase
        term    = term_w[47:0];
        base    = uop.first ? 48'(init_val) : r_acc;
        acc_new = uop.neg ? base - term : base + term;
        wr_val  = uop.sat ? 48'(sat32(acc_new)) : acc_new;
    end

    // Normaliser input: acceleration at sample accept, else the new quaternion
    always_comb begin
        norm_start = ((r_state == ST_IDLE) && i_in.valid) || (r_state == ST_QSTART);
        if (r_state == ST_IDLE) begin
            norm_in[0] = 36'(i_in.accel_x);
            norm_in[1] = 36'(i_in.accel_y);
            norm_in[2] = 36'(i_in.accel_z);
            norm_in[3] = '0;
        end else begin
            norm_in = r_qn;
        end
    end

    imuq_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (norm_start),
        .i_vec   (norm_in),
        .o_rsp   (norm_rsp),
        .o_vec   (norm_out)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_in.valid) n_state = ST_ANORM;
            ST_ANORM:  if (norm_rsp.done) n_state = ST_EXEC;
            ST_EXEC:   if (step_end && (r_step == STEP_LAST)) n_state = ST_QSTART;
            ST_QSTART: n_state = ST_QNORM;
            ST_QNORM:  if (norm_rsp.done) n_state = ST_DONE;
            ST_DONE:   if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        i_in.ready      = (r_state == ST_IDLE);
        i_cfg.ready     = 1'b1;
        o_out.valid     = r_out_valid;
        o_out.att_w     = r_res[0];
        o_out.att_x     = r_res[1];
        o_out.att_y     = r_res[2];
        o_out.att_z     = r_res[3];
        o_out.corrected = r_res_corr;
    end

    // Control state, gains and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_phase     <= 1'b0;
            r_corr      <= 1'b0;
            r_pg        <= PROP_GAIN_RST;
            r_ig        <= '0;
            r_q[0]      <= QONE;
            r_q[1]      <= '0;
            r_q[2]      <= '0;
            r_q[3]      <= '0;
            r_fb[0]     <= '0;
            r_fb[1]     <= '0;
            r_fb[2]     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // Take configuration writes
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_PROP_GAIN:  r_pg <= i_cfg.data;
                    CFG_INTEG_GAIN: r_ig <= i_cfg.data;
                    default:        ;
                endcase
            end

            // Acceleration normalised: pick the first step
            if ((r_state == ST_ANORM) && norm_rsp.done) begin
                r_corr  <= norm_rsp.nonzero;
                r_step  <= norm_rsp.nonzero ? '0 : STEP_RATE;
                r_phase <= 1'b0;
            end

            // Advance the micro-program
            if (r_state == ST_EXEC) begin
                if (step_end) begin
                    r_phase <= 1'b0;
                    r_step  <= r_step + 6'd1;
                end else begin
                    r_phase <= 1'b1;
                end
                if (r_phase) begin
                    case (uop.dst)
                        DST_FB0: r_fb[0] <= wr_val[31:0];
                        DST_FB1: r_fb[1] <= wr_val[31:0];
                        DST_FB2: r_fb[2] <= wr_val[31:0];
                        default: ;
                    endcase
                end
            end

            // Store the renormalised quaternion, or fall back to identity
            if ((r_state == ST_QNORM) && norm_rsp.done) begin
                if (norm_rsp.nonzero) begin
                    r_q <= norm_out;
                end else begin
                    r_q[0] <= QONE;
                    r_q[1] <= '0;
                    r_q[2] <= '0;
                    r_q[3] <= '0;
                end
            end

            // Output register: load the result, drop once taken
            if ((r_state == ST_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_g[0] <= i_in.rate_x;
            r_g[1] <= i_in.rate_y;
            r_g[2] <= i_in.rate_z;
            r_dt   <= i_in.step_time;
        end
        if ((r_state == ST_ANORM) && norm_rsp.done) begin
            r_ah[0] <= norm_out[0];
            r_ah[1] <= norm_out[1];
            r_ah[2] <= norm_out[2];
        end
        if ((r_state == ST_EXEC) && r_phase) begin
            r_acc <= acc_new;
            case (uop.dst)
                DST_HV0: r_hv[0] <= wr_val[32:0];
                DST_HV1: r_hv[1] <= wr_val[32:0];
                DST_HV2: r_hv[2] <= wr_val[32:0];
                DST_E0:  r_e[0]  <= wr_val[31:0];
                DST_E1:  r_e[1]  <= wr_val[31:0];
                DST_E2:  r_e[2]  <= wr_val[31:0];
                DST_T:   r_t     <= wr_val[31:0];
                DST_G0:  r_g[0]  <= wr_val[31:0];
                DST_G1:  r_g[1]  <= wr_val[31:0];
                DST_G2:  r_g[2]  <= wr_val[31:0];
                DST_H0:  r_h[0]  <= wr_val[31:0];
                DST_H1:  r_h[1]  <= wr_val[31:0];
                DST_H2:  r_h[2]  <= wr_val[31:0];
                DST_QN0: r_qn[0] <= wr_val[35:0];
                DST_QN1: r_qn[1] <= wr_val[35:0];
                DST_QN2: r_qn[2] <= wr_val[35:0];
                DST_QN3: r_qn[3] <= wr_val[35:0];
                default: ;
            endcase
        end
        if ((r_state == ST_DONE) && out_free) begin
            r_res      <= r_q;
            r_res_corr <= r_corr;
        end
    end

endmodule

`default_nettype wire

@@ sv/imuq_mul.sv @@
// ----------------------------------------------------------------------------
// imuq_mul
// Shared signed 33 x 33 multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module imuq_mul
    import imuq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_opnd i_a,
    input  t_opnd i_b,
    output t_prod o_prod
);

    t_prod r_prod;

    // Register the product when issued
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= 66'(i_a) * 66'(i_b);
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

@@ sv/imuq_norm.sv @@
// ----------------------------------------------------------------------------
// imuq_norm
// Iterative vector normaliser: sum of squares, square root and division,
// one step per cycle, giving each component in Q2.30.
// ----------------------------------------------------------------------------
`default_nettype none

module imuq_norm
    import imuq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_nin      i_vec [4],
    output t_norm_rsp o_rsp,
    output t_q        o_vec [4]
);

    t_nstate     r_state, n_state;
    logic        r_neg [4];
    logic [30:0] r_m [4];
    logic [63:0] r_sum;
    logic [4:0]  r_k;
    logic [1:0]  r_idx;
    logic [4:0]  r_cnt;
    logic [63:0] r_x;
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic [31:0] r_rem;
    logic [30:0] r_num;
    logic [30:0] r_quo;
    t_q          r_out [4];
    logic        r_done;
    logic        r_nz;

    logic [35:0] mag [4];
    logic [35:0] mor;
    logic [2:0]  shv;
    logic [61:0] sq;
    logic [63:0] trial;
    logic        sq_ge;
    logic [62:0] mk_w;
    logic [32:0] rem2;
    logic        dv_ge;

    // Magnitudes and the right shift that brings them below 2^31
    always_comb begin
        mor = '0;
        for (int i = 0; i < 4; i++) begin
            mag[i] = i_vec[i][35] ? 36'(-i_vec[i]) : 36'(i_vec[i]);
            mor    = mor | mag[i];
        end
        shv = 3'd5;
        for (int j = 5; j >= 0; j--) begin
            if ((mor >> j) < 36'd2147483648) begin
                shv = 3'(j);
            end
        end
    end

    // Square, root trial and division trial
    always_comb begin
        sq    = {31'b0, r_m[r_idx]} * {31'b0, r_m[r_idx]};
        trial = r_res + r_bit;
        sq_ge = (r_x >= trial);
        mk_w  = {32'b0, r_m[r_idx]} << r_k;
        rem2  = {r_rem, r_num[30]};
        dv_ge = (rem2 >= {1'b0, r_res[31:0]});
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            NS_IDLE:  if (i_start) n_state = NS_SQR;
            NS_SQR:   if (r_idx == 2'd3) n_state = NS_SCALE;
            NS_SCALE: begin
                if (r_sum == '0) begin
                    n_state = NS_IDLE;
                end else if (r_sum[63:62] != 2'b00) begin
                    n_state = NS_SQRT;
                end
            end
            NS_SQRT:  if (r_cnt == 5'd31) n_state = NS_DLOAD;
            NS_DLOAD: n_state = NS_DIV;
            NS_DIV: begin
                if (r_cnt == 5'd30) begin
                    n_state = (r_idx == 2'd3) ? NS_IDLE : NS_DLOAD;
                end
            end
            default:  n_state = NS_IDLE;
        endcase
    end

    // State and done flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= NS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= ((r_state == NS_SCALE) && (r_sum == '0)) ||
                       ((r_state == NS_DIV) && (r_cnt == 5'd30) && (r_idx == 2'd3));
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            NS_IDLE: begin
                if (i_start) begin
                    for (int i = 0; i < 4; i++) begin
                        r_neg[i] <= i_vec[i][35];
                        r_m[i]   <= 31'(mag[i] >> shv);
                    end
                    r_sum <= '0;
                    r_k   <= '0;
                    r_idx <= '0;
                end
            end
            NS_SQR: begin
                r_sum <= r_sum + {2'b00, sq};
                r_idx <= r_idx + 2'd1;
            end
            NS_SCALE: begin
                if (r_sum == '0) begin
                    r_nz <= 1'b0;
                end else if (r_sum[63:62] == 2'b00) begin
                    r_sum <= r_sum << 2;
                    r_k   <= r_k + 5'd1;
                end else begin
                    r_x   <= r_sum;
                    r_res <= '0;
                    r_bit <= 64'h4000_0000_0000_0000;
                    r_cnt <= '0;
                    r_nz  <= 1'b1;
                end
            end
            NS_SQRT: begin
                if (sq_ge) begin
                    r_x   <= r_x - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 5'd1;
            end
            NS_DLOAD: begin
                // numerator is m << (k + 30); the top part below the root is m << k >> 1
                r_rem <= {1'b0, mk_w[31:1]};
                r_num <= {mk_w[0], 30'b0};
                r_quo <= '0;
                r_cnt <= '0;
            end
            NS_DIV: begin
                r_rem <= dv_ge ? 32'(rem2 - {1'b0, r_res[31:0]}) : rem2[31:0];
                r_num <= r_num << 1;
                r_quo <= {r_quo[29:0], dv_ge};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd30) begin
                    r_out[r_idx] <= r_neg[r_idx] ? -$signed({1'b0, r_quo[29:0], dv_ge})
                                                 : $signed({1'b0, r_quo[29:0], dv_ge});
                    r_idx <= r_idx + 2'd1;
                end
            end
            default: ;
        endcase
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.nonzero = r_nz;
    assign o_vec         = r_out;

endmodule

`default_nettype wire
